### hdl/hex_bin_height_accumulator_top_defines.svh
// Assertion macros for the hex bin height accumulator.
// Included by the top level only; expects signals named clock and reset in scope.
`ifndef HEX_BIN_HEIGHT_ACCUMULATOR_TOP_DEFINES_SVH
`define HEX_BIN_HEIGHT_ACCUMULATOR_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HBHA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds a fixed number of cycles after the antecedent.
`define HBHA_ASSERT_LATER(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### hdl/hbha_pkg.sv
// Shared constants and types for the hex bin height accumulator.
// Used by every module of the block; depends on nothing.
package hbha_pkg;

   // Field widths of the pixel and result words.
   localparam int COORD_W = 9;
   localparam int CHAN_W  = 8;
   localparam int RGB_W   = 10;
   localparam int HEX_W   = 7;
   localparam int Q_W     = 8;
   localparam int R_W     = 8;
   localparam int SUM_W   = 28;
   localparam int COUNT_W = 19;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   // Default structural parameters.
   localparam int IMAGE_SIZE_DEF = 512;
   localparam int Q_OFFSET_DEF   = 128;
   localparam int TABLE_SIDE_DEF = 256;

   // Hex size register: reset value and usable range.
   localparam logic [HEX_W-1:0] HEX_SCALE_RESET = 7'd5;
   localparam logic [HEX_W-1:0] HEX_SCALE_MIN   = 7'd3;
   localparam logic [HEX_W-1:0] HEX_SCALE_MAX   = 7'd64;

   // sqrt(3) in Q16 and the width of its product with a coordinate.
   localparam int SQ3_W = 17;
   localparam logic [SQ3_W-1:0] SQ3_Q16 = 17'd113512;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 1 + COORD_W + FRAC_W;

   // Divider sizes: 10-bit dividends, divisor 3*s up to 192.
   localparam int DIV_W  = 10;
   localparam int DVSR_W = 8;

   // Saturation limits of a bin.
   localparam logic [SUM_W-1:0]   SUM_MAX   = 28'hFFFFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 19'h7FFFF;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // One classified pixel on its way to the bin update.
   typedef struct packed {
      logic [Q_W-1:0]   q;
      logic [R_W-1:0]   r;
      logic [RGB_W-1:0] rgb;
   } bin_item_type;

   // Status reported by the back part.
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

### hdl/hex_bin_height_accumulator_top.sv
// A pixel word passes the front sequencer, the queue and the bin update before
// its result word is registered. The front part, paced by its bit-serial divider,
// takes no new pixel until it has pushed the last one; the back part's bin update
// passes a pop state and an update state. Reset: synchronous, active high; then a
// clearing pass zeroes all TABLE_SIDE^2 bins (65536 by default) while no pixel is taken.
// Depends on hbha_pkg, hbha_front, hbha_queue, hbha_back and the assertion header.
`include "hex_bin_height_accumulator_top_defines.svh"

module hex_bin_height_accumulator_top #(
   parameter int IMAGE_SIZE = hbha_pkg::IMAGE_SIZE_DEF,
   parameter int Q_OFFSET   = hbha_pkg::Q_OFFSET_DEF,
   parameter int TABLE_SIDE = hbha_pkg::TABLE_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Hex size register write.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hbha_pkg::HEX_W-1:0]         csr_data,
   // Pixel words: pixel_x, pixel_y, red, green, blue from bit 0 up.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hbha_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Result words: hex_q, hex_r, bin_sum, bin_count from bit 0 up.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hbha_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   hbha_pkg::back_status_type  back_status;
   hbha_pkg::bin_item_type     push_item, head_item;
   logic                       q_push, q_full, q_pop, q_empty;

   // Intake and coordinate computation.
   hbha_front #(
      .IMAGE_SIZE (IMAGE_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // Decoupling queue.
   hbha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head_item),
      .empty     (q_empty)
   );

   // Bin table update and result register.
   hbha_back #(
      .Q_OFFSET   (Q_OFFSET),
      .TABLE_SIDE (TABLE_SIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (back_status),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_head     (head_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Design checks.
   `HBHA_ASSERT_NOW(a_no_rsp_while_clearing, back_status.clearing, !rsp_tvalid, "result during clear")
   `HBHA_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "queue overflow")
   `HBHA_ASSERT_NOW(a_count_nonzero, rsp_tvalid, rsp_tdata[62:44] != 19'd0, "empty bin result")
   `HBHA_ASSERT_LATER(a_pop_to_result, q_pop, 2, rsp_tvalid, "popped word not delivered")

endmodule

### hdl/hbha_div.sv
// Dual restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on hbha_pkg for the dividend and divisor widths.
module hbha_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hbha_pkg::DIV_W-1:0]    dividend_a,
   input  logic [hbha_pkg::DIV_W-1:0]    dividend_b,
   input  logic [hbha_pkg::DVSR_W-1:0]   divisor,
   output logic                          done,
   output logic [hbha_pkg::DIV_W-1:0]    quotient_a,
   output logic [hbha_pkg::DIV_W-1:0]    quotient_b
);

   localparam int STEP_W = $clog2(hbha_pkg::DIV_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(hbha_pkg::DIV_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [hbha_pkg::DIV_W-1:0]    num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic [hbha_pkg::DVSR_W-1:0]   rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [hbha_pkg::DVSR_W-1:0]   dvsr_ff, dvsr_in;
   logic [hbha_pkg::DVSR_W:0]     step_a, step_b;

   // One restoring step: returns the new remainder above the quotient bit.
   function automatic logic [hbha_pkg::DVSR_W:0] div_step(
      input logic [hbha_pkg::DVSR_W-1:0] rem,
      input logic                        bit_in,
      input logic [hbha_pkg::DVSR_W-1:0] dv
   );
      logic [hbha_pkg::DVSR_W:0] trial;
      logic [hbha_pkg::DVSR_W:0] diff;
      logic                      ge;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, dv};
      ge    = (trial >= {1'b0, dv});
      if (ge) begin
         return {diff[hbha_pkg::DVSR_W-1:0], 1'b1};
      end else begin
         return {trial[hbha_pkg::DVSR_W-1:0], 1'b0};
      end
   endfunction

   assign step_a = div_step(rem_a_ff, num_a_ff[hbha_pkg::DIV_W-1], dvsr_ff);
   assign step_b = div_step(rem_b_ff, num_b_ff[hbha_pkg::DIV_W-1], dvsr_ff);

   // Next-state logic: load on start, then shift one quotient bit in per cycle.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         num_a_in = dividend_a;
         num_b_in = dividend_b;
         rem_a_in = '0;
         rem_b_in = '0;
         dvsr_in  = divisor;
      end else if (busy_ff) begin
         num_a_in = {num_a_ff[hbha_pkg::DIV_W-2:0], step_a[0]};
         num_b_in = {num_b_ff[hbha_pkg::DIV_W-2:0], step_b[0]};
         rem_a_in = step_a[hbha_pkg::DVSR_W:1];
         rem_b_in = step_b[hbha_pkg::DVSR_W:1];
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers take reset; the datapath does not need it.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      dvsr_ff  <= dvsr_in;
   end

   assign done       = done_ff;
   assign quotient_a = num_a_ff;
   assign quotient_b = num_b_ff;

endmodule

### hdl/hbha_front.sv
// Front part: hex size register, pixel intake, axial coordinate computation.
// Depends on hbha_pkg and instantiates hbha_div.
module hbha_front #(
   parameter int IMAGE_SIZE = hbha_pkg::IMAGE_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hbha_pkg::HEX_W-1:0]         csr_data,
   // Pixel words: pixel_x, pixel_y, red, green, blue from bit 0 up.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hbha_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Link to the queue and the back part.
   input  hbha_pkg::back_status_type          back_status,
   input  logic                               q_full,
   output logic                               q_push,
   output hbha_pkg::bin_item_type             q_item
);

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_PREP, F_DIV, F_PUSH} front_state_type;

   localparam logic [hbha_pkg::COORD_W-1:0] COORD_MAX =
      hbha_pkg::COORD_W'(IMAGE_SIZE - 1);

   front_state_type                    state_ff, state_in;
   logic [hbha_pkg::HEX_W-1:0]         hex_scale_ff, hex_scale_in;
   logic [hbha_pkg::COORD_W-1:0]       x_ff, x_in, y_ff, y_in;
   logic [hbha_pkg::RGB_W-1:0]         rgb_ff, rgb_in;
   logic [hbha_pkg::DVSR_W-1:0]        s3_ff, s3_in;
   logic [hbha_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic                               sign_ff, sign_in;
   hbha_pkg::bin_item_type             item_ff, item_in;

   logic [hbha_pkg::COORD_W-1:0]       pix_x, pix_y;
   logic [hbha_pkg::CHAN_W-1:0]        pix_red, pix_green, pix_blue;
   logic [hbha_pkg::HEX_W-1:0]         size_use;
   logic [hbha_pkg::PROD_W-1:0]        neg_term, diff;
   logic                               sign_c;
   logic                               accept;
   logic                               div_start, div_done;
   logic [hbha_pkg::DIV_W-1:0]         quot_q, quot_r;

   // Unpack the pixel word.
   assign pix_x     = req_tdata[8:0];
   assign pix_y     = req_tdata[17:9];
   assign pix_red   = req_tdata[25:18];
   assign pix_green = req_tdata[33:26];
   assign pix_blue  = req_tdata[41:34];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == F_IDLE) && !back_status.clearing;
   assign accept     = req_tvalid && req_tready;

   // Hex size limited to its usable range.
   always_comb begin
      if (hex_scale_ff < hbha_pkg::HEX_SCALE_MIN) begin
         size_use = hbha_pkg::HEX_SCALE_MIN;
      end else if (hex_scale_ff > hbha_pkg::HEX_SCALE_MAX) begin
         size_use = hbha_pkg::HEX_SCALE_MAX;
      end else begin
         size_use = hex_scale_ff;
      end
   end

   // Magnitude and sign of sqrt(3)*x - y in Q16.
   assign neg_term = {1'b0, y_ff, {hbha_pkg::FRAC_W{1'b0}}};
   assign sign_c   = (prod_ff < neg_term);
   assign diff     = sign_c ? (neg_term - prod_ff) : (prod_ff - neg_term);

   // The Q16 scaling drops out by truncating the fraction before dividing by 3s.
   assign div_start = (state_ff == F_PREP);

   hbha_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_a (diff[hbha_pkg::PROD_W-1:hbha_pkg::FRAC_W]),
      .dividend_b ({y_ff, 1'b0}),
      .divisor    (s3_ff),
      .done       (div_done),
      .quotient_a (quot_q),
      .quotient_b (quot_r)
   );

   // Sequencer for one pixel at a time.
   always_comb begin
      state_in     = state_ff;
      hex_scale_in = hex_scale_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rgb_in       = rgb_ff;
      s3_in        = s3_ff;
      prod_in      = prod_ff;
      sign_in      = sign_ff;
      item_in      = item_ff;
      q_push       = 1'b0;
      if (csr_valid) begin
         hex_scale_in = csr_data;
      end
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               x_in   = (pix_x > COORD_MAX) ? COORD_MAX : pix_x;
               y_in   = (pix_y > COORD_MAX) ? COORD_MAX : pix_y;
               rgb_in = hbha_pkg::RGB_W'(pix_red) + hbha_pkg::RGB_W'(pix_green)
                        + hbha_pkg::RGB_W'(pix_blue);
               s3_in  = {1'b0, size_use} + {size_use, 1'b0};
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in  = hbha_pkg::PROD_W'(hbha_pkg::PROD_W'(hbha_pkg::SQ3_Q16)
                       * hbha_pkg::PROD_W'(x_ff));
            state_in = F_PREP;
         end
         F_PREP: begin
            sign_in  = sign_c;
            state_in = F_DIV;
         end
         F_DIV: begin
            if (div_done) begin
               item_in.q   = sign_ff ? hbha_pkg::Q_W'(hbha_pkg::DIV_W'(0) - quot_q)
                                     : hbha_pkg::Q_W'(quot_q);
               item_in.r   = hbha_pkg::R_W'(quot_r);
               item_in.rgb = rgb_ff;
               state_in    = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // State, register and datapath storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         hex_scale_ff <= hbha_pkg::HEX_SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         hex_scale_ff <= hex_scale_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      rgb_ff  <= rgb_in;
      s3_ff   <= s3_in;
      prod_ff <= prod_in;
      sign_ff <= sign_in;
      item_ff <= item_in;
   end

   assign q_item = item_ff;

endmodule

### hdl/hbha_queue.sv
// Short queue of classified pixels between the front and back parts.
// Depends on hbha_pkg for the item type and the depth.
module hbha_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hbha_pkg::bin_item_type  push_item,
   output logic                    full,
   input  logic                    pop,
   output hbha_pkg::bin_item_type  head,
   output logic                    empty
);

   localparam int PTR_W = $clog2(hbha_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(hbha_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hbha_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hbha_pkg::QUEUE_DEPTH - 1);

   hbha_pkg::bin_item_type  slots_ff [hbha_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/hbha_back.sv
// Back part: bin table clearing pass, read-modify-write of a bin, result register.
// Depends on hbha_pkg; holds the bin memory.
module hbha_back #(
   parameter int Q_OFFSET   = hbha_pkg::Q_OFFSET_DEF,
   parameter int TABLE_SIDE = hbha_pkg::TABLE_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   output hbha_pkg::back_status_type          status,
   input  logic                               q_empty,
   output logic                               q_pop,
   input  hbha_pkg::bin_item_type             q_head,
   // Result words: hex_q, hex_r, bin_sum, bin_count from bit 0 up.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hbha_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPDATE} back_state_type;

   typedef struct packed {
      logic [hbha_pkg::SUM_W-1:0]   sum;
      logic [hbha_pkg::COUNT_W-1:0] count;
   } bin_entry_type;

   localparam int DEPTH  = TABLE_SIDE * TABLE_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = 10;
   // A row or column up to 255 over a side of at least 64 needs three subtractions.
   localparam int WRAP_STEPS = 3;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic signed [IDX_W-1:0] SIDE_S   = IDX_W'(TABLE_SIDE);
   localparam logic signed [IDX_W-1:0] OFFSET_S = IDX_W'(Q_OFFSET);
   localparam logic [hbha_pkg::R_W:0]  SIDE_U   = (hbha_pkg::R_W + 1)'(TABLE_SIDE);

   bin_entry_type                  bin_mem_ff [DEPTH];
   bin_entry_type                  rd_data_ff;
   back_state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]              clear_addr_ff, clear_addr_in;
   logic [ADDR_W-1:0]              addr_ff, addr_in;
   hbha_pkg::bin_item_type         item_ff, item_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hbha_pkg::Q_W-1:0]       rsp_q_ff, rsp_q_in;
   logic [hbha_pkg::R_W-1:0]       rsp_r_ff, rsp_r_in;
   logic [hbha_pkg::SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic [hbha_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic signed [IDX_W-1:0]        row_s, row_fix;
   logic [hbha_pkg::R_W:0]         col_fix;
   logic [ADDR_W-1:0]              rd_addr;
   logic [hbha_pkg::SUM_W:0]       sum_wide;
   logic [hbha_pkg::COUNT_W:0]     count_wide;
   bin_entry_type                  new_entry, wr_data;
   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;

   // Table index of the queue head: row from q plus offset, column from r,
   // each reduced modulo the table side.
   always_comb begin
      row_s = $signed({{(IDX_W - hbha_pkg::Q_W){q_head.q[hbha_pkg::Q_W-1]}}, q_head.q})
              + OFFSET_S;
      row_fix = (row_s < 0) ? (row_s + SIDE_S) : row_s;
      col_fix = {1'b0, q_head.r};
      for (int k = 0; k < WRAP_STEPS; k++) begin
         if (row_fix >= SIDE_S) begin
            row_fix = row_fix - SIDE_S;
         end
         if (col_fix >= SIDE_U) begin
            col_fix = col_fix - SIDE_U;
         end
      end
      rd_addr = ADDR_W'(ADDR_W'($unsigned(row_fix)) * ADDR_W'(TABLE_SIDE)
                + ADDR_W'(col_fix));
   end

   // Saturating update of the bin just read.
   always_comb begin
      sum_wide   = {1'b0, rd_data_ff.sum} + (hbha_pkg::SUM_W + 1)'(item_ff.rgb);
      count_wide = {1'b0, rd_data_ff.count} + 1'b1;
      new_entry.sum   = (sum_wide > {1'b0, hbha_pkg::SUM_MAX}) ? hbha_pkg::SUM_MAX
                        : sum_wide[hbha_pkg::SUM_W-1:0];
      new_entry.count = (count_wide > {1'b0, hbha_pkg::COUNT_MAX}) ? hbha_pkg::COUNT_MAX
                        : count_wide[hbha_pkg::COUNT_W-1:0];
   end

   // Sequencer: clearing pass after reset, then one bin update at a time.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      addr_in       = addr_ff;
      item_in       = item_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_q_in      = rsp_q_ff;
      rsp_r_in      = rsp_r_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_count_in  = rsp_count_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = new_entry;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_data       = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_LAST) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty && (!rsp_valid_ff || rsp_tready)) begin
               q_pop    = 1'b1;
               addr_in  = rd_addr;
               item_in  = q_head;
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            wr_en        = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_q_in     = item_ff.q;
            rsp_r_in     = item_ff.r;
            rsp_sum_in   = new_entry.sum;
            rsp_count_in = new_entry.count;
            state_in     = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      item_ff      <= item_in;
      rsp_q_ff     <= rsp_q_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Bin memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= bin_mem_ff[rd_addr];
   end

   assign status.clearing = (state_ff == B_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_sum_ff, rsp_r_ff, rsp_q_ff};

endmodule

### dv/hex_bin_tally_checker.sv
`timescale 1ns / 1ps
// Checker for the hex bin height accumulator: watches the register, pixel and result
// channels, keeps its own copy of the bin table and compares every result word.
// Depends on hbha_pkg for the field widths, limits and table parameters.
module hex_bin_tally_checker
   import hbha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [HEX_W-1:0]      csr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_x, pixel_y, red, green, blue
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // hex_q, hex_r, bin_sum, bin_count
   input  logic                  drain_done,
   output int                    words_pending,
   output int                    fail_count
);

   localparam int BIN_DEPTH   = TABLE_SIDE_DEF * TABLE_SIDE_DEF;
   localparam int TABLE_MASK  = TABLE_SIDE_DEF - 1;
   localparam int PRINT_LIMIT = 60;

   // One expected result word, field by field.
   typedef struct packed {
      logic [Q_W-1:0]     q;
      logic [R_W-1:0]     r;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } bin_word_type;

   logic [HEX_W-1:0]   hex_scale;
   logic [SUM_W-1:0]   tally_sum   [BIN_DEPTH];
   logic [COUNT_W-1:0] tally_count [BIN_DEPTH];
   bin_word_type       expected_bins [$];
   int                 word_number;
   bit                 leftovers_checked;

   // Prints one line per failure, up to a limit, and counts every one.
   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT)
         $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result word %0d: %s is 0x%0h, expected 0x%0h",
                                   word_number, name, got, want));
   endtask

   // Maps a pixel to its hexagon, updates that bin and returns the expected word.
   function automatic bin_word_type tally_pixel(input logic [REQ_DATA_W-1:0] word);
      longint       x, y, rgb, s, pos, neg, dq, sum, cnt;
      int           q, r, slot;
      bin_word_type res;
      x   = word[0 +: COORD_W];
      y   = word[COORD_W +: COORD_W];
      rgb = longint'(word[2*COORD_W +: CHAN_W]) + longint'(word[2*COORD_W+CHAN_W +: CHAN_W])
            + longint'(word[2*COORD_W+2*CHAN_W +: CHAN_W]);
      if (x >= IMAGE_SIZE_DEF) x = IMAGE_SIZE_DEF - 1;
      if (y >= IMAGE_SIZE_DEF) y = IMAGE_SIZE_DEF - 1;
      s = hex_scale;
      if (s < HEX_SCALE_MIN) s = HEX_SCALE_MIN;
      if (s > HEX_SCALE_MAX) s = HEX_SCALE_MAX;

      // Both quotients truncate toward zero; sqrt(3) is carried in Q16.
      pos = longint'(SQ3_Q16) * x;
      neg = 65536 * y;
      dq  = 3 * 65536 * s;
      if (pos >= neg)
         q = int'((pos - neg) / dq);
      else
         q = -int'((neg - pos) / dq);
      r = int'((2 * y) / (3 * s));

      // The table is indexed by offset q and r, wrapped to the table side.
      slot = ((q + Q_OFFSET_DEF) & TABLE_MASK) * TABLE_SIDE_DEF + (r & TABLE_MASK);
      sum  = longint'(tally_sum[slot]) + rgb;
      if (sum > longint'(SUM_MAX)) sum = SUM_MAX;
      cnt  = longint'(tally_count[slot]) + 1;
      if (cnt > longint'(COUNT_MAX)) cnt = COUNT_MAX;
      tally_sum[slot]   = SUM_W'(sum);
      tally_count[slot] = COUNT_W'(cnt);

      res.q     = Q_W'(q);
      res.r     = R_W'(r);
      res.sum   = SUM_W'(sum);
      res.count = COUNT_W'(cnt);
      return res;
   endfunction

   // Samples every handshake at the rising edge, before the drivers update.
   always @(posedge clock) begin : watch
      bin_word_type got, want;
      if (reset) begin
         hex_scale = HEX_SCALE_RESET;
         for (int i = 0; i < BIN_DEPTH; i++) begin
            tally_sum[i]   = '0;
            tally_count[i] = '0;
         end
         expected_bins.delete();
         word_number       = 0;
         fail_count        = 0;
         leftovers_checked = 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            hex_scale = csr_data;
         if (req_tvalid && req_tready)
            expected_bins.push_back(tally_pixel(req_tdata));

         // Each result word is held against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got.q     = rsp_tdata[0 +: Q_W];
            got.r     = rsp_tdata[Q_W +: R_W];
            got.sum   = rsp_tdata[Q_W+R_W +: SUM_W];
            got.count = rsp_tdata[Q_W+R_W+SUM_W +: COUNT_W];
            if (expected_bins.size() == 0) begin
               report_mismatch($sformatf("result word %0d arrived with none expected",
                                         word_number));
            end else begin
               want = expected_bins.pop_front();
               check_field("hex_q", 32'(got.q), 32'(want.q));
               check_field("hex_r", 32'(got.r), 32'(want.r));
               check_field("bin_sum", 32'(got.sum), 32'(want.sum));
               check_field("bin_count", 32'(got.count), 32'(want.count));
            end
            word_number++;
         end

         // At the end of the run any prediction still waiting is a failure.
         if (drain_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            foreach (expected_bins[i])
               report_mismatch($sformatf("expected result word %0d never arrived",
                                         word_number + i));
         end
      end
      words_pending <= expected_bins.size();
   end

endmodule

### dv/hex_bin_height_accumulator_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the hex bin height accumulator: directed pixels, then
// random phases over several hex sizes and idle patterns. Needs hbha_pkg and the checker.
module hex_bin_height_accumulator_top_test;
   import hbha_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASE_COUNT     = 8;
   localparam int WORDS_PER_PHASE = 55;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [HEX_W-1:0]      csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // pixel_x, pixel_y, red, green, blue
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // hex_q, hex_r, bin_sum, bin_count
   logic                  drain_done = 1'b0;
   int                    words_pending;
   int                    fail_count;
   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   int                    cycle_count    = 0;
   logic [COORD_W-1:0]    hot_x = '0;
   logic [COORD_W-1:0]    hot_y = '0;

   hex_bin_height_accumulator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hex_bin_tally_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .drain_done    (drain_done),
      .words_pending (words_pending),
      .fail_count    (fail_count)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Guard against a hung block; the clearing pass after reset is well inside this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("hex_bin_height_accumulator_top: mismatch");
         $finish;
      end
   end

   // The result side stalls at random according to the current phase.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic set_idle_mode(input idle_mode_type mode);
      send_idle_pct  <= (mode == IDLE_SENDER) ? 56 : (mode == IDLE_BOTH) ? 31 : 0;
      recv_stall_pct <= (mode == IDLE_RECEIVER) ? 56 : (mode == IDLE_BOTH) ? 31 : 0;
   endtask

   // Offers one pixel word, after a random idle gap, and holds it until accepted.
   task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({blue, green, red, y, x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Holds the pixel side idle until every predicted result word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   task automatic write_hex_scale(input logic [HEX_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Channel bytes lean toward the extremes now and then.
   function automatic logic [CHAN_W-1:0] pick_channel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // Most pixels land near a hot spot so bins fill up; the rest are anywhere.
   task automatic send_random_pixel();
      logic [COORD_W-1:0] x, y;
      if ($urandom_range(99) < 60) begin
         x = hot_x + COORD_W'($urandom_range(7));
         y = hot_y + COORD_W'($urandom_range(7));
      end else begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end
      send_pixel(x, y, pick_channel(), pick_channel(), pick_channel());
   endtask

   initial begin
      logic [HEX_W-1:0] phase_sizes [PHASE_COUNT];
      phase_sizes = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65,
                      HEX_W'($urandom_range(3, 64)), HEX_W'($urandom_range(127))};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_idle_mode(IDLE_NONE);

      // Directed pixels at the reset hex size: corners, bit patterns, bin edges.
      send_pixel(9'd0, 9'd0, 8'h00, 8'h00, 8'h00);
      send_pixel(9'd0, 9'd0, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(9'd511, 9'd0, 8'h01, 8'h02, 8'h03);
      send_pixel(9'd0, 9'd511, 8'hFF, 8'h00, 8'hFF);
      send_pixel(9'd511, 9'd511, 8'h80, 8'h7F, 8'h80);
      send_pixel(9'h155, 9'h0AA, 8'h55, 8'hAA, 8'h55);
      send_pixel(9'h0AA, 9'h155, 8'hAA, 8'h55, 8'hAA);
      // Rows on either side of the first r step.
      send_pixel(9'd0, 9'd7, 8'h10, 8'h20, 8'h30);
      send_pixel(9'd0, 9'd8, 8'h10, 8'h20, 8'h30);
      // Negative q truncates toward zero, then reaches minus one.
      send_pixel(9'd0, 9'd14, 8'h01, 8'h01, 8'h01);
      send_pixel(9'd0, 9'd15, 8'h01, 8'h01, 8'h01);
      // Columns on either side of the first positive q step.
      send_pixel(9'd8, 9'd0, 8'hFE, 8'hFE, 8'hFE);
      send_pixel(9'd9, 9'd0, 8'hFE, 8'hFE, 8'hFE);
      // The same bin again and again, so the count climbs.
      repeat (4) send_pixel(9'd300, 9'd200, 8'hFF, 8'hFF, 8'hFF);

      // Random phases, each with its own hex size and idle pattern.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_hex_scale(phase_sizes[p]);
         set_idle_mode(idle_mode_type'(p % 4));
         hot_x = COORD_W'($urandom_range(504));
         hot_y = COORD_W'($urandom_range(504));
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(39) == 0)
               wait_drained();
            send_random_pixel();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("hex_bin_height_accumulator_top: match");
      else
         $display("hex_bin_height_accumulator_top: mismatch");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/hbha_pkg.sv
hdl/hbha_div.sv
hdl/hbha_front.sv
hdl/hbha_queue.sv
hdl/hbha_back.sv
hdl/hex_bin_height_accumulator_top.sv
dv/hex_bin_tally_checker.sv
dv/hex_bin_height_accumulator_top_test.sv
